>>> src/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define GVPS_ASSERT_CLK(lbl, ck, rst_n, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) prop) \
		else $error("gvps assertion failed");

// Concurrent assertion on the block clock and reset.
`define GVPS_ASSERT(lbl, prop) `GVPS_ASSERT_CLK(lbl, clk, arst_n, prop)

`endif

>>> src/gvps_pkg.sv
// ----------------------------------------------------------------------------
// gvps_pkg
// Shared types, constants and key compare for the gain vector priority set.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gvps_pkg;

	localparam int MODULES = 1024;
	localparam int LEVELS  = 2;
	localparam int GAIN_W  = 16;
	localparam int STAMP_W = 32;
	localparam int MOD_W   = 10;
	localparam int CNT_W   = 11;
	localparam int ADDR_W  = $clog2(MODULES);
	localparam int SCAN_W  = $clog2(MODULES + 1);
	localparam int QDEPTH  = 2;

	typedef enum logic [1:0] {
		ACT_SET    = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_CLEAR  = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		K_SET,
		K_REMOVE,
		K_CLEAR,
		K_NOP
	} kind_t;

	typedef logic [LEVELS-1:0][GAIN_W-1:0] key_t;

	typedef struct packed {
		kind_t            kind;
		logic [MOD_W-1:0] module_id;
		key_t             key;
	} req_t;

	typedef struct packed {
		logic               flag;
		key_t               key;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

	typedef enum logic [2:0] {
		B_SWEEP,
		B_IDLE,
		B_READ,
		B_UPDATE,
		B_SCAN,
		B_REPORT
	} bstate_t;

	// Lexicographic signed compare, level 0 most significant.
	function automatic logic key_gt(input key_t a, input key_t b);
		logic decided;
		logic gt;
		decided = 1'b0;
		gt      = 1'b0;
		for (int i = 0; i < LEVELS; i++) begin
			if (!decided && (a[i] != b[i])) begin
				decided = 1'b1;
				gt      = $signed(a[i]) > $signed(b[i]);
			end
		end
		return gt;
	endfunction

endpackage

>>> src/gvps_front.sv
// ----------------------------------------------------------------------------
// gvps_front
// Accepts requests, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gvps_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [1:0]                     action,
	input  logic [gvps_pkg::MOD_W-1:0]     module_req,
	input  logic signed [gvps_pkg::GAIN_W-1:0] key_0,
	input  logic signed [gvps_pkg::GAIN_W-1:0] key_1,
	input  logic signed [gvps_pkg::GAIN_W-1:0] key_2,
	input  logic signed [gvps_pkg::GAIN_W-1:0] key_3,
	output logic                           req_valid,
	output gvps_pkg::req_t                 req,
	input  logic                           pop
);

	localparam int PW = $clog2(gvps_pkg::QDEPTH);

	logic [3:0][gvps_pkg::GAIN_W-1:0] keys_all;
	gvps_pkg::req_t                   in_req;
	gvps_pkg::req_t                   queue_q [gvps_pkg::QDEPTH];
	logic [PW-1:0]                    wptr_q;
	logic [PW-1:0]                    rptr_q;
	logic [PW:0]                      fill_q;
	logic                             push;
	logic                             in_range;

	assign keys_all = {key_3, key_2, key_1, key_0};
	assign in_range = 32'(module_req) < 32'(gvps_pkg::MODULES);

	always_comb begin
		in_req.module_id = module_req;
		for (int i = 0; i < gvps_pkg::LEVELS; i++) begin
			in_req.key[i] = keys_all[i];
		end
		case (action)
			gvps_pkg::ACT_SET:    in_req.kind = in_range ? gvps_pkg::K_SET : gvps_pkg::K_NOP;
			gvps_pkg::ACT_REMOVE: in_req.kind = in_range ? gvps_pkg::K_REMOVE : gvps_pkg::K_NOP;
			gvps_pkg::ACT_CLEAR:  in_req.kind = gvps_pkg::K_CLEAR;
			default:              in_req.kind = gvps_pkg::K_NOP;
		endcase
	end

	assign busy      = (fill_q == (PW+1)'(gvps_pkg::QDEPTH));
	assign push      = start && !busy;
	assign req_valid = (fill_q != '0);
	assign req       = queue_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wptr_q] <= in_req;
		end
	end

endmodule

>>> src/gvps_back.sv
// ----------------------------------------------------------------------------
// gvps_back
// Executes queued requests against the member store and tracks the maximum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gvps_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	input  gvps_pkg::req_t                    req,
	output logic                              pop,
	output logic                              done,
	output logic                              max_valid,
	output logic [gvps_pkg::MOD_W-1:0]        max_module,
	output logic [gvps_pkg::CNT_W-1:0]        member_count
);

	localparam int AW = gvps_pkg::ADDR_W;
	localparam int SW = gvps_pkg::SCAN_W;

	gvps_pkg::bstate_t               state_q, state_d;
	gvps_pkg::entry_t                mem [gvps_pkg::MODULES];
	gvps_pkg::entry_t                rdata_q;
	gvps_pkg::entry_t                wdata;
	logic                            mem_we;
	logic [AW-1:0]                   mem_addr;
	gvps_pkg::req_t                  cur_q;
	logic [SW-1:0]                   scan_q;
	logic                            rep_q;
	logic [gvps_pkg::CNT_W-1:0]      count_q;
	logic [gvps_pkg::STAMP_W-1:0]    stamp_q;
	logic                            bvalid_q;
	logic [gvps_pkg::MOD_W-1:0]      best_q;
	gvps_pkg::key_t                  bk_q;
	logic [gvps_pkg::STAMP_W-1:0]    bs_q;
	logic                            is_set;
	logic                            is_best;
	logic                            new_eq;
	logic                            new_above;
	logic                            rescan;
	logic                            scan_take;
	logic [gvps_pkg::MOD_W-1:0]      scan_mod;

	assign is_set  = (cur_q.kind == gvps_pkg::K_SET);
	assign is_best = bvalid_q && (cur_q.module_id == best_q);
	assign new_eq  = (cur_q.key == bk_q);
	// A freshly set module against the held best.
	assign new_above = gvps_pkg::key_gt(cur_q.key, bk_q)
		|| (new_eq && (stamp_q > bs_q))
		|| (new_eq && (stamp_q == bs_q) && (cur_q.module_id < best_q));

	always_comb begin
		if (is_set) begin
			rescan = is_best && !(gvps_pkg::key_gt(cur_q.key, bk_q)
				|| (new_eq && (stamp_q > bs_q)));
		end else begin
			rescan = rdata_q.flag && is_best;
		end
	end

	assign scan_mod  = gvps_pkg::MOD_W'(scan_q - 1'b1);
	assign scan_take = (scan_q != '0) && rdata_q.flag && (!bvalid_q
		|| gvps_pkg::key_gt(rdata_q.key, bk_q)
		|| ((rdata_q.key == bk_q) && (rdata_q.stamp > bs_q)));

	always_comb begin
		state_d = state_q;
		case (state_q)
			gvps_pkg::B_SWEEP: begin
				if (scan_q == SW'(gvps_pkg::MODULES - 1)) begin
					state_d = rep_q ? gvps_pkg::B_REPORT : gvps_pkg::B_IDLE;
				end
			end
			gvps_pkg::B_IDLE: begin
				if (req_valid) begin
					case (req.kind)
						gvps_pkg::K_CLEAR: state_d = gvps_pkg::B_SWEEP;
						gvps_pkg::K_NOP:   state_d = gvps_pkg::B_REPORT;
						default:           state_d = gvps_pkg::B_READ;
					endcase
				end
			end
			gvps_pkg::B_READ:   state_d = gvps_pkg::B_UPDATE;
			gvps_pkg::B_UPDATE: state_d = rescan ? gvps_pkg::B_SCAN : gvps_pkg::B_REPORT;
			gvps_pkg::B_SCAN: begin
				if (scan_q == SW'(gvps_pkg::MODULES)) begin
					state_d = gvps_pkg::B_REPORT;
				end
			end
			gvps_pkg::B_REPORT: state_d = gvps_pkg::B_IDLE;
			default:            state_d = gvps_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		mem_we   = 1'b0;
		mem_addr = scan_q[AW-1:0];
		wdata    = rdata_q;
		pop      = 1'b0;
		done     = 1'b0;
		case (state_q)
			gvps_pkg::B_SWEEP: begin
				mem_we     = 1'b1;
				wdata.flag = 1'b0;
			end
			gvps_pkg::B_IDLE:  pop = req_valid;
			gvps_pkg::B_READ:  mem_addr = AW'(cur_q.module_id);
			gvps_pkg::B_UPDATE: begin
				mem_addr = AW'(cur_q.module_id);
				if (is_set) begin
					mem_we      = 1'b1;
					wdata.flag  = 1'b1;
					wdata.key   = cur_q.key;
					wdata.stamp = stamp_q;
				end else begin
					mem_we     = rdata_q.flag;
					wdata.flag = 1'b0;
				end
			end
			gvps_pkg::B_REPORT: done = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= wdata;
		end
		rdata_q <= mem[mem_addr];
		if (pop) begin
			cur_q <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= gvps_pkg::B_SWEEP;
			scan_q   <= '0;
			rep_q    <= 1'b0;
			count_q  <= '0;
			stamp_q  <= '0;
			bvalid_q <= 1'b0;
			best_q   <= '0;
			bk_q     <= '0;
			bs_q     <= '0;
		end else begin
			state_q <= state_d;
			if ((state_q == gvps_pkg::B_SWEEP) || (state_q == gvps_pkg::B_SCAN)) begin
				scan_q <= scan_q + 1'b1;
			end else begin
				scan_q <= '0;
			end
			if (pop && (req.kind == gvps_pkg::K_CLEAR)) begin
				rep_q    <= 1'b1;
				count_q  <= '0;
				bvalid_q <= 1'b0;
			end
			if (state_q == gvps_pkg::B_UPDATE) begin
				if (is_set) begin
					stamp_q <= stamp_q + 1'b1;
					if (!rdata_q.flag) begin
						count_q <= count_q + 1'b1;
					end
					if (rescan) begin
						bvalid_q <= 1'b0;
					end else if (!bvalid_q || is_best || new_above) begin
						bvalid_q <= 1'b1;
						best_q   <= cur_q.module_id;
						bk_q     <= cur_q.key;
						bs_q     <= stamp_q;
					end
				end else if (rdata_q.flag) begin
					count_q <= count_q - 1'b1;
					if (rescan) begin
						bvalid_q <= 1'b0;
					end
				end
			end
			if ((state_q == gvps_pkg::B_SCAN) && scan_take) begin
				bvalid_q <= 1'b1;
				best_q   <= scan_mod;
				bk_q     <= rdata_q.key;
				bs_q     <= rdata_q.stamp;
			end
		end
	end

	assign max_valid    = bvalid_q;
	assign max_module   = bvalid_q ? best_q : '0;
	assign member_count = count_q;

endmodule

>>> src/gain_vector_priority_set.sv
// Sequence: a set or remove that the held best decides steps through the read, update and
// report states and puts its result on done; a no-op goes straight to report. One that displaces
// the best rescans the store, one entry a cycle, and then reports.
// A clear sweeps the store and then reports. The back end works on one request at a
// time. Reset: control clears at once; a store sweep follows, during which requests
// queue up to the queue depth. No result stalls.
// ----------------------------------------------------------------------------
// gain_vector_priority_set
// Priority set of module numbers keyed by signed gain vectors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gain_vector_priority_set (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [1:0]                         action,
	input  logic [gvps_pkg::MOD_W-1:0]         module_req,
	input  logic signed [gvps_pkg::GAIN_W-1:0] key_0,
	input  logic signed [gvps_pkg::GAIN_W-1:0] key_1,
	input  logic signed [gvps_pkg::GAIN_W-1:0] key_2,
	input  logic signed [gvps_pkg::GAIN_W-1:0] key_3,
	output logic                               done,
	output logic                               max_valid,
	output logic [gvps_pkg::MOD_W-1:0]         max_module,
	output logic [gvps_pkg::CNT_W-1:0]         member_count
);

	// The front end takes each request, sorts it into set, remove, clear or
	// no-op (out-of-range module or unused action code) and parks it in a
	// two-entry queue. busy is simply the queue being full, so requests are
	// taken while the back end is still working on an earlier one.
	logic           req_valid;
	gvps_pkg::req_t req;
	logic           pop;

	gvps_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.action     (action),
		.module_req (module_req),
		.key_0      (key_0),
		.key_1      (key_1),
		.key_2      (key_2),
		.key_3      (key_3),
		.req_valid  (req_valid),
		.req        (req),
		.pop        (pop)
	);

	// The back end owns the member store (flag, key and set stamp per module)
	// and the held best. Most requests update the best from a single compare;
	// only losing the current best forces a full pass over the store. Each
	// request produces exactly one done pulse with the current result.
	gvps_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req          (req),
		.pop          (pop),
		.done         (done),
		.max_valid    (max_valid),
		.max_module   (max_module),
		.member_count (member_count)
	);

endmodule

>>> src/gvps_checker.sv
// ----------------------------------------------------------------------------
// gvps_checker
// Port-level checks on the result stream of the priority set.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gvps_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               start,
	input logic                               busy,
	input logic [1:0]                         action,
	input logic [gvps_pkg::MOD_W-1:0]         module_req,
	input logic signed [gvps_pkg::GAIN_W-1:0] key_0,
	input logic signed [gvps_pkg::GAIN_W-1:0] key_1,
	input logic signed [gvps_pkg::GAIN_W-1:0] key_2,
	input logic signed [gvps_pkg::GAIN_W-1:0] key_3,
	input logic                               done,
	input logic                               max_valid,
	input logic [gvps_pkg::MOD_W-1:0]         max_module,
	input logic [gvps_pkg::CNT_W-1:0]         member_count
);

	`GVPS_ASSERT(a_done_single, done |=> !done)
	`GVPS_ASSERT(a_empty_module_zero, (done && !max_valid) |-> (max_module == '0))
	`GVPS_ASSERT(a_valid_matches_count, done |-> (max_valid == (member_count != '0)))
	`GVPS_ASSERT(a_count_bound, done |-> (member_count <= gvps_pkg::CNT_W'(gvps_pkg::MODULES)))

endmodule

bind gain_vector_priority_set gvps_checker u_gvps_checker (.*);
